/* hdl/double_ended_queue_assert.svh */
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared property shorthands for the queue checks, sampled on clk, off in rst.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define DQ_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed: same-cycle implication");

// Next-cycle implication.
`define DQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed: next-cycle implication");

`endif

/* hdl/dq_pkg.sv */
// ----------------------------------------------------------------------------
// Deque package
// Widths, operation and status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;
  localparam int KIND_W        = 2;
  localparam int STATUS_W      = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic put_back;
    logic put_front;
    logic take_back;
    logic take_front;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/dq_cell.sv */
// ----------------------------------------------------------------------------
// Deque cell
// One storage slot of the chain with its occupied flag; shifts with neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dq_cell (
  input  wire                            clk,
  input  wire                            rst,
  input  wire dq_pkg::cell_ctrl_t        ctrl,
  input  wire logic [dq_pkg::DATA_W-1:0] push_value,
  input  wire logic [dq_pkg::DATA_W-1:0] left_data,
  input  wire logic                      left_occ,
  input  wire logic [dq_pkg::DATA_W-1:0] right_data,
  input  wire logic                      right_occ,
  output logic      [dq_pkg::DATA_W-1:0] data,
  output logic                           occ,
  output logic      [dq_pkg::DATA_W-1:0] tap
);
  import dq_pkg::*;

  logic is_back;
  logic is_slot;

  assign is_back = occ & ~right_occ;
  assign is_slot = ~occ & left_occ;
  assign tap     = is_back ? data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.put_front) begin
      occ <= left_occ;
    end else if (ctrl.put_back) begin
      if (is_slot) begin
        occ <= 1'b1;
      end
    end else if (ctrl.take_front) begin
      occ <= right_occ;
    end else if (ctrl.take_back) begin
      if (is_back) begin
        occ <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.put_front) begin
      data <= left_data;
    end else if (ctrl.put_back) begin
      if (is_slot) begin
        data <= push_value;
      end
    end else if (ctrl.take_front) begin
      data <= right_data;
    end
  end

endmodule

`default_nettype wire

/* hdl/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// Double-ended queue
// Chain of storage cells holding up to DEPTH signed words, front at cell 0.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): kind selects push back, push front,
// pop back or pop front; value is the word to push and is ignored by pops.
// Output channel (out_valid / out_stall): one transfer per input transfer,
// carrying popped_value (zero unless a pop succeeded), status (ok, empty on
// a pop of an empty queue, full on a push to a full queue) and occupancy
// after the operation.
// Output valid rises in the cycle after input transfer; throughput is one
// operation per cycle while unstalled: every cell shifts or loads in the
// same cycle, and the back entry is picked out by an AND-OR of cell taps.
// The result register frees up in the cycle it is taken, so a new input is
// accepted whenever the output is empty or being taken. While the receiver
// stalls with a result waiting, in_stall is high and the result holds.
// Failed pushes and pops leave the contents unchanged.
// Reset clears the occupied flags and the count; the queue comes up empty
// and accepts input as soon as reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [dq_pkg::KIND_W-1:0]   kind,
  input  wire logic signed [dq_pkg::DATA_W-1:0] value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [dq_pkg::DATA_W-1:0] popped_value,
  output logic      [dq_pkg::STATUS_W-1:0] status,
  output logic      [CNT_W-1:0]            occupancy
);
  import dq_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              accept;
  logic              is_full;
  logic              is_empty;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] back_value;
  logic [DATA_W-1:0] pop_value;
  logic [STATUS_W-1:0] op_status;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_tap  [DEPTH];
  logic [DEPTH-1:0]  cell_occ;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign is_full  = (count == FULL_CNT);
  assign is_empty = (count == '0);

  always_comb begin
    ctrl       = '0;
    count_next = count;
    op_status  = STATUS_OK;
    pop_value  = '0;
    unique case (kind)
      KIND_PUSH_BACK: begin
        if (is_full) begin
          op_status = STATUS_FULL;
        end else begin
          ctrl.put_back = accept;
          count_next    = count + 1'b1;
        end
      end
      KIND_PUSH_FRONT: begin
        if (is_full) begin
          op_status = STATUS_FULL;
        end else begin
          ctrl.put_front = accept;
          count_next     = count + 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (is_empty) begin
          op_status = STATUS_EMPTY;
        end else begin
          ctrl.take_back = accept;
          count_next     = count - 1'b1;
          pop_value      = back_value;
        end
      end
      KIND_POP_FRONT: begin
        if (is_empty) begin
          op_status = STATUS_EMPTY;
        end else begin
          ctrl.take_front = accept;
          count_next      = count - 1'b1;
          pop_value       = cell_data[0];
        end
      end
      default: begin
        op_status = STATUS_OK;
      end
    endcase
  end

  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | cell_tap[i];
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic              left_occ;
    logic [DATA_W-1:0] right_data;
    logic              right_occ;

    if (i == 0) begin : g_first
      assign left_data = value;
      assign left_occ  = 1'b1;
    end else begin : g_mid_left
      assign left_data = cell_data[i-1];
      assign left_occ  = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
      assign right_occ  = 1'b0;
    end else begin : g_mid_right
      assign right_data = cell_data[i+1];
      assign right_occ  = cell_occ[i+1];
    end

    dq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .push_value (value),
      .left_data  (left_data),
      .left_occ   (left_occ),
      .right_data (right_data),
      .right_occ  (right_occ),
      .data       (cell_data[i]),
      .occ        (cell_occ[i]),
      .tap        (cell_tap[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_value <= pop_value;
      status       <= op_status;
      occupancy    <= count_next;
    end
  end

`include "double_ended_queue_assert.svh"

  `DQ_ASSERT_IMPLY(a_count_bound, 1'b1, count <= FULL_CNT)
  `DQ_ASSERT_IMPLY(a_occ_matches_count, 1'b1, $countones(cell_occ) == int'(count))
  `DQ_ASSERT_IMPLY(a_full_status, out_valid && status == STATUS_FULL, occupancy == FULL_CNT)
  `DQ_ASSERT_IMPLY(a_empty_status, out_valid && status == STATUS_EMPTY, occupancy == '0 && popped_value == '0)
  `DQ_ASSERT_NEXT(a_result_follows, accept, out_valid && occupancy == count)

endmodule

`default_nettype wire
